/* hw/rtl/qte_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qte_pkg
// Shared types, widths and constants for the quaternion to Euler converter.
// ----------------------------------------------------------------------------
package qte_pkg;

  localparam int CORDIC_STAGES_DEF   = 16;
  localparam int COMPONENT_WIDTH_DEF = 16;

  localparam int COMP_W   = 16;  // component after read-in
  localparam int PROD_W   = 32;  // component products
  localparam int N_W      = 33;  // squared norm, unsigned
  localparam int OP_W     = 35;  // atan2 operands, signed
  localparam int MAG_W    = 35;  // operand magnitudes
  localparam int MSB_W    = 6;   // bit index into a magnitude
  localparam int XW       = 43;  // CORDIC x/y datapath
  localparam int ZW       = 34;  // CORDIC angle accumulator, Q30 radians
  localparam int NORM_MSB = 39;  // normalized operand top bit
  localparam int PIT_W    = 31;  // pitch operands, norm scaled to [2^30, 2^31)
  localparam int PIT_MSB  = 30;
  localparam int SQ_BITS  = 31;  // root bits
  localparam int RAD_W    = 62;  // radicand
  localparam int KW       = 28;  // width of the radian to turn factor
  localparam int OUT_SHIFT = 44;
  localparam int ANG_W    = 16;

  localparam logic signed [ZW-1:0]    HALF_PI_Q30    = 34'sd1686629713;
  localparam logic [KW-1:0]           INV_TWO_PI_Q30 = 28'd170891319;
  localparam logic signed [ANG_W-1:0] QUARTER_TURN   = 16'sd16384;

  typedef struct packed {
    logic signed [COMP_W-1:0] quat_w;
    logic signed [COMP_W-1:0] quat_x;
    logic signed [COMP_W-1:0] quat_y;
    logic signed [COMP_W-1:0] quat_z;
  } quat_t;

  typedef struct packed {
    logic signed [ANG_W-1:0] roll_angle;
    logic signed [ANG_W-1:0] pitch_angle;
    logic signed [ANG_W-1:0] yaw_angle;
    logic                    gimbal_clamped;
  } euler_t;

  // one CORDIC cell's worth of state
  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } rot_t;

  // one root cell's worth of state
  typedef struct packed {
    logic [RAD_W-1:0]   rem;
    logic [SQ_BITS-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic zero;
    logic clamp;
    logic sneg;
  } pflag_t;

  typedef struct packed {
    logic signed [OP_W-1:0] yaw_y;
    logic signed [OP_W-1:0] yaw_x;
    logic signed [OP_W-1:0] roll_y;
    logic signed [OP_W-1:0] roll_x;
    logic [PIT_W-1:0]       pit_s;
    pflag_t                 flags;
  } side_t;

  // atan(2^-i) in Q30, rounded to nearest
  function automatic logic [31:0] atan_q30(input int idx);
    logic [31:0] v;
    unique case (idx)
      0:       v = 32'd843314857;
      1:       v = 32'd497837829;
      2:       v = 32'd263043837;
      3:       v = 32'd133525159;
      4:       v = 32'd67021687;
      5:       v = 32'd33543516;
      6:       v = 32'd16775851;
      7:       v = 32'd8388437;
      8:       v = 32'd4194283;
      9:       v = 32'd2097149;
      default: v = 32'd1 << (30 - idx);
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/quaternion_to_euler_angles.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// Converts one Q2.14 quaternion per cycle into Z-Y-X Euler binary angles.
// ----------------------------------------------------------------------------
// Usage:
//   Drive quat and pulse start; an item is taken on any edge with start high
//   and busy low. busy is high only during reset, so one item can enter every
//   cycle. Each item comes out on euler with done high for exactly one cycle,
//   in order. The receiver cannot stall; results are not held.
//   The pipeline holds 7 stages of read-in, products, sums and pitch
//   prescaling, a 31-cell square root chain for the pitch cosine, then three
//   parallel atan2 units of CORDIC_STAGES + 5 stages, then the output register.
//   Throughput is one item per cycle.
//   Reset clears only the valid chain; the data path carries no state between
//   items. A zero quaternion yields all-zero angles.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles #(
  parameter int CORDIC_STAGES   = qte_pkg::CORDIC_STAGES_DEF,
  parameter int COMPONENT_WIDTH = qte_pkg::COMPONENT_WIDTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  input  wire qte_pkg::quat_t quat,
  output logic                done,
  output qte_pkg::euler_t     euler
);

  localparam int CL  = CORDIC_STAGES + 5;
  localparam int LAT = 7 + qte_pkg::SQ_BITS + CL + 1;
  localparam int CW  = qte_pkg::COMP_W;
  localparam int PW  = qte_pkg::PROD_W;
  localparam int OW  = qte_pkg::OP_W;

  logic [LAT-1:0] vld;

  // read-in stage
  logic [CW-1:0]        raw    [4];
  logic signed [CW-1:0] comp_c [4];
  logic signed [CW-1:0] cw, cx, cy, cz;

  // products
  logic signed [PW-1:0] ww, xx, yy, zz, wz, xy, wx, yz, wy, zx;

  // sums
  logic [qte_pkg::N_W-1:0] n_c, n2;
  logic signed [OW-1:0]    s2;
  qte_pkg::side_t          side2, side3, side4, side5, side6;
  logic signed [OW-1:0]    n_ext;

  // pitch prescale
  logic [OW-2:0]             abs_c, abs3;
  logic [qte_pkg::N_W-1:0]   n3;
  logic [qte_pkg::MSB_W-1:0] msb_c;
  logic [1:0]                shr3;
  logic [4:0]                shl3;
  logic [qte_pkg::PIT_W-1:0] nn4;
  logic [qte_pkg::PIT_W-1:0] d5;
  logic [qte_pkg::PIT_W:0]   e5;
  qte_pkg::sqrt_t            sq [qte_pkg::SQ_BITS+1];

  // delay lines
  qte_pkg::side_t  side_dly [qte_pkg::SQ_BITS];
  qte_pkg::pflag_t flag_dly [CL];
  qte_pkg::pflag_t fl;

  logic signed [qte_pkg::ANG_W-1:0] yaw_a, roll_a, pit_a;

  assign busy = rst;

  // valid chain: advance every cycle, drop everything on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start & ~busy};
    end
  end
  assign done = vld[LAT-1];

  assign raw[0] = quat.quat_w;
  assign raw[1] = quat.quat_x;
  assign raw[2] = quat.quat_y;
  assign raw[3] = quat.quat_z;

  // narrow components sign-extend from their low bits; wide ones shift right, zero-filled
  for (genvar g = 0; g < 4; g++) begin : g_read
    if (COMPONENT_WIDTH <= CW) begin : g_narrow
      assign comp_c[g] = CW'($signed(raw[g][COMPONENT_WIDTH-1:0]));
    end else begin : g_wide
      assign comp_c[g] = $signed(raw[g] >> (COMPONENT_WIDTH - CW));
    end
  end

  always_ff @(posedge clk) begin
    cw <= comp_c[0];
    cx <= comp_c[1];
    cy <= comp_c[2];
    cz <= comp_c[3];
  end

  always_ff @(posedge clk) begin
    ww <= cw * cw;
    xx <= cx * cx;
    yy <= cy * cy;
    zz <= cz * cz;
    wz <= cw * cz;
    xy <= cx * cy;
    wx <= cw * cx;
    yz <= cy * cz;
    wy <= cw * cy;
    zx <= cz * cx;
  end

  // n - 2(a^2 + b^2) keeps the angles scale-free without dividing by n
  always_comb begin
    n_c = qte_pkg::N_W'($unsigned(ww)) + qte_pkg::N_W'($unsigned(xx)) +
          qte_pkg::N_W'($unsigned(yy)) + qte_pkg::N_W'($unsigned(zz));
    n_ext = $signed({2'b00, n_c});
  end

  always_ff @(posedge clk) begin
    n2           <= n_c;
    s2           <= (OW'(wy) - OW'(zx)) <<< 1;
    side2.yaw_y  <= (OW'(wz) + OW'(xy)) <<< 1;
    side2.yaw_x  <= n_ext - ((OW'(yy) + OW'(zz)) <<< 1);
    side2.roll_y <= (OW'(wx) + OW'(yz)) <<< 1;
    side2.roll_x <= n_ext - ((OW'(xx) + OW'(yy)) <<< 1);
    side2.pit_s  <= '0;
    side2.flags  <= '0;
  end

  // find the shift that puts n in [2^30, 2^31)
  always_comb begin
    abs_c = s2[OW-1] ? (OW-1)'(-s2) : s2[OW-2:0];
    msb_c = '0;
    for (int i = 0; i < qte_pkg::N_W; i++) begin
      if (n2[i]) begin
        msb_c = qte_pkg::MSB_W'(i);
      end
    end
  end

  // flags: zero norm, gimbal lock, negative sine
  always_ff @(posedge clk) begin
    side3 <= {side2.yaw_y, side2.yaw_x, side2.roll_y, side2.roll_x, side2.pit_s,
              n2 == '0, abs_c >= (OW-1)'(n2), s2[OW-1]};
    n3    <= n2;
    abs3  <= abs_c;
    shr3 <= (msb_c > qte_pkg::MSB_W'(qte_pkg::PIT_MSB)) ?
            2'(msb_c - qte_pkg::MSB_W'(qte_pkg::PIT_MSB)) : 2'd0;
    shl3 <= (msb_c < qte_pkg::MSB_W'(qte_pkg::PIT_MSB)) ?
            5'(qte_pkg::MSB_W'(qte_pkg::PIT_MSB) - msb_c) : 5'd0;
  end

  // scale n and |s| together; shifting down truncates both
  always_ff @(posedge clk) begin
    side4 <= {side3.yaw_y, side3.yaw_x, side3.roll_y, side3.roll_x,
              qte_pkg::PIT_W'((abs3 >> shr3) << shl3), side3.flags};
    nn4   <= qte_pkg::PIT_W'((n3 >> shr3) << shl3);
  end

  always_ff @(posedge clk) begin
    side5 <= side4;
    d5    <= nn4 - side4.pit_s;
    e5    <= (qte_pkg::PIT_W+1)'(nn4) + (qte_pkg::PIT_W+1)'(side4.pit_s);
  end

  // radicand (n - |s|)(n + |s|) = n^2 - s^2
  always_ff @(posedge clk) begin
    side6       <= side5;
    sq[0].rem   <= qte_pkg::RAD_W'(d5) * qte_pkg::RAD_W'(e5);
    sq[0].root  <= '0;
  end

  for (genvar g = 0; g < qte_pkg::SQ_BITS; g++) begin : g_sqrt
    qte_sqrt_cell #(.BIT(qte_pkg::SQ_BITS - 1 - g)) u_cell (
      .clk   (clk),
      .d_in  (sq[g]),
      .d_out (sq[g+1])
    );
  end

  // hold the side data alongside the root cells
  always_ff @(posedge clk) begin
    side_dly[0] <= side6;
    for (int i = 1; i < qte_pkg::SQ_BITS; i++) begin
      side_dly[i] <= side_dly[i-1];
    end
  end

  qte_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
    .clk   (clk),
    .y_in  (side_dly[qte_pkg::SQ_BITS-1].yaw_y),
    .x_in  (side_dly[qte_pkg::SQ_BITS-1].yaw_x),
    .angle (yaw_a)
  );

  qte_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
    .clk   (clk),
    .y_in  (side_dly[qte_pkg::SQ_BITS-1].roll_y),
    .x_in  (side_dly[qte_pkg::SQ_BITS-1].roll_x),
    .angle (roll_a)
  );

  // pitch = atan2(|s|, sqrt(n^2 - s^2)), sign restored at the output
  qte_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
    .clk   (clk),
    .y_in  (OW'(side_dly[qte_pkg::SQ_BITS-1].pit_s)),
    .x_in  (OW'(sq[qte_pkg::SQ_BITS].root)),
    .angle (pit_a)
  );

  // hold the pitch flags across the atan2 latency
  always_ff @(posedge clk) begin
    flag_dly[0] <= side_dly[qte_pkg::SQ_BITS-1].flags;
    for (int i = 1; i < CL; i++) begin
      flag_dly[i] <= flag_dly[i-1];
    end
  end
  assign fl = flag_dly[CL-1];

  always_ff @(posedge clk) begin
    euler.yaw_angle      <= fl.zero ? '0 : yaw_a;
    euler.roll_angle     <= fl.zero ? '0 : roll_a;
    euler.gimbal_clamped <= fl.clamp & ~fl.zero;
    if (fl.zero) begin
      euler.pitch_angle <= '0;
    end else if (fl.clamp) begin
      // gimbal lock: pin to a quarter turn
      euler.pitch_angle <= fl.sneg ? -qte_pkg::QUARTER_TURN : qte_pkg::QUARTER_TURN;
    end else begin
      euler.pitch_angle <= fl.sneg ? -pit_a : pit_a;
    end
  end

  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without a matching item");

  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (euler.pitch_angle <= qte_pkg::QUARTER_TURN) &&
             (euler.pitch_angle >= -qte_pkg::QUARTER_TURN))
    else $error("pitch beyond a quarter turn");

  a_clamp_pitch: assert property (@(posedge clk) disable iff (rst)
    (done && euler.gimbal_clamped) |->
      (euler.pitch_angle == qte_pkg::QUARTER_TURN) ||
      (euler.pitch_angle == -qte_pkg::QUARTER_TURN))
    else $error("clamped item without pinned pitch");

endmodule
`default_nettype wire

/* hw/rtl/qte_cordic_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qte_cordic_cell
// One vectoring CORDIC micro-rotation, registered.
// ----------------------------------------------------------------------------
module qte_cordic_cell #(
  parameter int STAGE = 0
) (
  input  wire logic          clk,
  input  wire qte_pkg::rot_t d_in,
  output qte_pkg::rot_t      d_out
);

  localparam logic signed [qte_pkg::ZW-1:0] ATAN =
    qte_pkg::ZW'(qte_pkg::atan_q30(STAGE));

  logic signed [qte_pkg::XW-1:0] dx, dy;
  qte_pkg::rot_t                 d_next;

  always_comb begin
    dx     = d_in.x >>> STAGE;
    dy     = d_in.y >>> STAGE;
    d_next = d_in;
    // rotate toward the x axis
    if (d_in.y > 0) begin
      d_next.x = d_in.x + dy;
      d_next.y = d_in.y - dx;
      d_next.z = d_in.z + ATAN;
    end else begin
      d_next.x = d_in.x - dy;
      d_next.y = d_in.y + dx;
      d_next.z = d_in.z - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    d_out <= d_next;
  end

endmodule
`default_nettype wire

/* hw/rtl/qte_sqrt_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qte_sqrt_cell
// One bit of a restoring integer square root, registered.
// ----------------------------------------------------------------------------
module qte_sqrt_cell #(
  parameter int BIT = 0
) (
  input  wire logic           clk,
  input  wire qte_pkg::sqrt_t d_in,
  output qte_pkg::sqrt_t      d_out
);

  localparam int TW = qte_pkg::RAD_W + 1;

  logic [TW-1:0]  trial, rem_ext;
  qte_pkg::sqrt_t d_next;

  always_comb begin
    // (root + 2^b)^2 - root^2 = root*2^(b+1) + 2^(2b)
    trial   = (TW'(d_in.root) << (BIT + 1)) + (TW'(1) << (2 * BIT));
    rem_ext = TW'(d_in.rem);
    d_next  = d_in;
    if (rem_ext >= trial) begin
      d_next.rem       = qte_pkg::RAD_W'(rem_ext - trial);
      d_next.root[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    d_out <= d_next;
  end

endmodule
`default_nettype wire

/* hw/rtl/qte_cordic.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qte_cordic
// Pipelined atan2: normalize, quadrant fold, a row of CORDIC cells, then
// scale Q30 radians to a 16-bit binary angle.
// ----------------------------------------------------------------------------
module qte_cordic #(
  parameter int STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic                           clk,
  input  wire logic signed [qte_pkg::OP_W-1:0] y_in,
  input  wire logic signed [qte_pkg::OP_W-1:0] x_in,
  output logic signed [qte_pkg::ANG_W-1:0]     angle
);

  localparam int MW = qte_pkg::ZW + qte_pkg::KW;
  localparam int RW = MW - qte_pkg::OUT_SHIFT;

  // magnitude stage
  logic signed [qte_pkg::OP_W-1:0] xa, ya;
  logic [qte_pkg::MAG_W-1:0]       ax_c, ay_c, ma;

  // leading-one stage
  logic signed [qte_pkg::OP_W-1:0] xb, yb;
  logic [qte_pkg::MSB_W-1:0]       msb_c, kb;
  logic                            zb;

  // shift and fold
  logic signed [qte_pkg::XW-1:0] xs, ys;
  qte_pkg::rot_t                 fold_c;
  qte_pkg::rot_t                 chain [STAGES+1];

  // output scaling
  logic [qte_pkg::ZW-1:0] az_c;
  logic [MW-1:0]          prod;
  logic                   zneg, zzero;
  logic [MW-1:0]          rnd_c;
  logic [RW-1:0]          r_c;

  always_comb begin
    ax_c = qte_pkg::MAG_W'(x_in[qte_pkg::OP_W-1] ? -x_in : x_in);
    ay_c = qte_pkg::MAG_W'(y_in[qte_pkg::OP_W-1] ? -y_in : y_in);
  end

  always_ff @(posedge clk) begin
    xa <= x_in;
    ya <= y_in;
    ma <= (ax_c > ay_c) ? ax_c : ay_c;
  end

  always_comb begin
    msb_c = '0;
    for (int i = 0; i < qte_pkg::MAG_W; i++) begin
      if (ma[i]) begin
        msb_c = qte_pkg::MSB_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    xb <= xa;
    yb <= ya;
    zb <= (ma == '0);
    kb <= qte_pkg::MSB_W'(qte_pkg::NORM_MSB) - msb_c;
  end

  always_comb begin
    xs          = qte_pkg::XW'(xb) <<< kb;
    ys          = qte_pkg::XW'(yb) <<< kb;
    fold_c.x    = xs;
    fold_c.y    = ys;
    fold_c.z    = '0;
    fold_c.zero = zb;
    // fold the left half plane by a quarter turn
    if (xs < 0) begin
      if (ys >= 0) begin
        fold_c.x = ys;
        fold_c.y = -xs;
        fold_c.z = qte_pkg::HALF_PI_Q30;
      end else begin
        fold_c.x = -ys;
        fold_c.y = xs;
        fold_c.z = -qte_pkg::HALF_PI_Q30;
      end
    end
  end

  always_ff @(posedge clk) begin
    chain[0] <= fold_c;
  end

  for (genvar g = 0; g < STAGES; g++) begin : g_cell
    qte_cordic_cell #(.STAGE(g)) u_cell (
      .clk   (clk),
      .d_in  (chain[g]),
      .d_out (chain[g+1])
    );
  end

  assign az_c = qte_pkg::ZW'(chain[STAGES].z[qte_pkg::ZW-1] ?
                             -chain[STAGES].z : chain[STAGES].z);

  always_ff @(posedge clk) begin
    prod  <= MW'(az_c) * MW'(qte_pkg::INV_TWO_PI_Q30);
    zneg  <= chain[STAGES].z[qte_pkg::ZW-1];
    zzero <= chain[STAGES].zero;
  end

  always_comb begin
    // round half away from zero on the magnitude
    rnd_c = prod + (MW'(1) << (qte_pkg::OUT_SHIFT - 1));
    r_c   = rnd_c[MW-1:qte_pkg::OUT_SHIFT];
  end

  always_ff @(posedge clk) begin
    if (zzero) begin
      angle <= '0;
    end else if (zneg) begin
      angle <= qte_pkg::ANG_W'(-r_c);
    end else begin
      angle <= qte_pkg::ANG_W'(r_c);
    end
  end

endmodule
`default_nettype wire

/* test/tb_quaternion_to_euler_angles.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quaternion_to_euler_angles
// Self-checking bench: feeds quaternions and compares each Euler-angle item
// against a bit-true fixed-point CORDIC predictor built into the bench.
// ----------------------------------------------------------------------------
module tb_quaternion_to_euler_angles;

  localparam int STAGES   = 16;
  localparam int LATENCY  = 60;
  localparam int WD_LIMIT = 2000;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            start = 1'b0;
  logic            busy;
  qte_pkg::quat_t  quat = '0;
  logic            done;
  qte_pkg::euler_t euler;

  quaternion_to_euler_angles dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .quat(quat), .done(done), .euler(euler)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  qte_pkg::quat_t  pending_quats[$];
  qte_pkg::euler_t expected_angles[$];
  longint atan_rom[STAGES];
  int     send_idle_pct = 0;
  int     errors = 0;
  int     n_sent = 0;
  int     n_checked = 0;
  int     n_gimbal = 0;
  int     quiet_cycles = 0;

  // Q30 arctangent table, computed once from the arctangent power series.
  function automatic longint atan_entry(int i);
    longint sum;
    longint term;
    int k;
    sum = 0;
    if (i == 0) return 64'd843314857;
    for (k = 0; i * (2 * k + 1) <= 62; k++) begin
      term = (64'sd1 <<< (62 - i * (2 * k + 1))) / (2 * k + 1);
      sum = (k & 1) ? sum - term : sum + term;
    end
    return longint'((longint'(sum) + (64'sd1 <<< 31)) >>> 32);
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  // Vectoring CORDIC: angle of (x, y) as a 16-bit binary angle.
  function automatic logic signed [15:0] vec_angle(longint y, longint x);
    longint z;
    longint t;
    longint m;
    longint dx;
    longint dy;
    longint unsigned prod;
    longint r;
    z = 0;
    if (x == 0 && y == 0) return '0;
    m = mag(x) > mag(y) ? mag(x) : mag(y);
    while (m < (64'sd1 <<< 39)) begin
      x = x * 2; y = y * 2; m = m <<< 1;
    end
    while (m >= (64'sd1 <<< 40)) begin
      x = x >>> 1; y = y >>> 1; m = m >>> 1;
    end
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = 64'sd1686629713;
      end else begin
        x = -y; y = t; z = -64'sd1686629713;
      end
    end
    for (int i = 0; i < STAGES; i++) begin
      dx = x >>> i;
      dy = y >>> i;
      if (y > 0) begin
        x += dy; y -= dx; z += atan_rom[i];
      end else begin
        x -= dy; y += dx; z -= atan_rom[i];
      end
    end
    prod = longint'(mag(z)) * 64'd170891319;
    r = longint'((prod + (64'd1 << 43)) >> 44);
    return z < 0 ? 16'(-r) : 16'(r);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic qte_pkg::euler_t euler_of(qte_pkg::quat_t q);
    qte_pkg::euler_t e;
    longint w, x, y, z, n, s;
    longint unsigned nn, as, c;
    logic signed [15:0] p;
    w = q.quat_w; x = q.quat_x; y = q.quat_y; z = q.quat_z;
    e = '0;
    n = w * w + x * x + y * y + z * z;
    if (n == 0) return e;
    e.yaw_angle  = vec_angle(2 * (w * z + x * y), n - 2 * (y * y + z * z));
    e.roll_angle = vec_angle(2 * (w * x + y * z), n - 2 * (x * x + y * y));
    s = 2 * (w * y - z * x);
    if (mag(s) >= n) begin
      e.gimbal_clamped = 1'b1;
      e.pitch_angle = s > 0 ? qte_pkg::QUARTER_TURN : -qte_pkg::QUARTER_TURN;
    end else begin
      nn = n;
      as = mag(s);
      while (nn >= (64'd1 << 31)) begin
        nn >>= 1; as >>= 1;
      end
      while (nn < (64'd1 << 30)) begin
        nn <<= 1; as <<= 1;
      end
      c = int_sqrt((nn - as) * (nn + as));
      p = vec_angle(longint'(as), longint'(c));
      e.pitch_angle = s < 0 ? -p : p;
    end
    return e;
  endfunction

  function automatic logic signed [15:0] rnd_comp();
    unique case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      1:       return 16'($signed($urandom_range(0, 64)) - 32);
      2:       return 16'($urandom_range(0, 32767)) >>> $urandom_range(0, 14);
      default: return 16'($urandom());
    endcase
  endfunction

  // Random quaternion in Q2.14, scaled down by a random shift, with a chance of
  // pitch sitting right on the gimbal-lock line.
  task automatic push_rand();
    qte_pkg::quat_t q;
    int sh;
    q = {rnd_comp(), rnd_comp(), rnd_comp(), rnd_comp()};
    sh = $urandom_range(0, 3);
    if ($urandom_range(0, 9) == 0) begin
      // w = y, x = -z  ->  s equals n: gimbal lock
      q.quat_w = rnd_comp() >>> 1;
      q.quat_y = q.quat_w;
      q.quat_x = rnd_comp() >>> 1;
      q.quat_z = -q.quat_x;
      if ($urandom_range(0, 1)) begin
        q.quat_y = -q.quat_w;
        q.quat_z = q.quat_x;
      end
    end else if (sh != 0) begin
      q.quat_w = q.quat_w >>> sh; q.quat_x = q.quat_x >>> sh;
      q.quat_y = q.quat_y >>> sh; q.quat_z = q.quat_z >>> sh;
    end
    pending_quats.push_back(q);
  endtask

  // Driver: hold start high while items wait, drop it on idle cycles.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        expected_angles.push_back(euler_of(quat));
        n_sent <= n_sent + 1;
      end
      if ((!start || !busy) && pending_quats.size() != 0 &&
          $urandom_range(1, 100) > send_idle_pct) begin
        start <= 1'b1;
        quat  <= pending_quats.pop_front();
      end else if (!start || !busy) begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: compare each strobed item with the oldest expectation.
  always @(posedge clk) begin
    qte_pkg::euler_t want;
    if (!rst) begin
      quiet_cycles <= (done || (start && !busy)) ? 0 : quiet_cycles + 1;
      if (done) begin
        if (expected_angles.size() == 0) begin
          $display("%0t: unexpected item %p", $time, euler);
          errors <= errors + 1;
        end else begin
          want = expected_angles.pop_front();
          n_checked <= n_checked + 1;
          if (want.gimbal_clamped) n_gimbal <= n_gimbal + 1;
          if (euler !== want) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, euler);
            errors <= errors + 1;
          end
        end
      end
      if (quiet_cycles >= WD_LIMIT) begin
        $display("%0t: watchdog expired, %0d pending", $time, expected_angles.size());
        $display("quaternion_to_euler_angles verification failed");
        $finish;
      end
    end
  end

  initial begin
    int pct[4];
    pct = '{0, 71, 0, 30};
    for (int i = 0; i < STAGES; i++) atan_rom[i] = atan_entry(i);
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: identity, zero, extremes, gimbal lock both ways, half turns
    pending_quats.push_back('{16'sd16384, 16'sd0, 16'sd0, 16'sd0});
    pending_quats.push_back('0);
    pending_quats.push_back('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff});
    pending_quats.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
    pending_quats.push_back('{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000});
    pending_quats.push_back('{16'sd11585, 16'sd0, 16'sd11585, 16'sd0});
    pending_quats.push_back('{16'sd11585, 16'sd0, -16'sd11585, 16'sd0});
    pending_quats.push_back('{16'sd1, 16'sd0, 16'sd1, 16'sd0});
    pending_quats.push_back('{16'sd0, 16'sd16384, 16'sd0, 16'sd0});
    pending_quats.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd16384});
    pending_quats.push_back('{16'sd0, 16'sd0, 16'sd16384, 16'sd0});
    pending_quats.push_back('{16'sd0, -16'sd1, 16'sd0, 16'sd0});
    pending_quats.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd1});
    pending_quats.push_back('{-16'sd16384, 16'sd0, 16'sd0, 16'sd0});
    pending_quats.push_back('{16'sd8192, 16'sd8192, 16'sd8192, -16'sd8192});

    // random phases: none, sender idle, full rate again, mixed idling
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = pct[ph];
      for (int i = 0; i < 400; i++) push_rand();
      wait (pending_quats.size() == 0 && !start);
    end
    wait (expected_angles.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);

    $display("Checked %0d of %0d quaternions, %0d in gimbal lock, over four idling phases.",
             n_checked, n_sent, n_gimbal);
    if (errors == 0) begin
      $display("quaternion_to_euler_angles verification clean");
    end else begin
      $display("quaternion_to_euler_angles verification failed");
    end
    $finish;
  end
endmodule
